// File: hw/rtl/ira_pkg.sv
// ----------------------------------------------------------------------------
// ira_pkg: shared types, constants and functions for integer_to_radix_ascii
// Radix limits, ASCII mapping, the back-end state type and the division step.
// ----------------------------------------------------------------------------
`default_nettype none

package ira_pkg;

    // Default width of the input value
    localparam int DEF_VALUE_WIDTH = 31;

    // Radix register
    localparam int          RADIX_W     = 5;
    localparam logic [4:0]  RADIX_RESET = 5'd10;
    localparam logic [4:0]  RADIX_MIN   = 5'd2;
    localparam logic [4:0]  RADIX_MAX   = 5'd16;

    // Configuration bus
    localparam int          APB_DATA_W    = 32;
    localparam int          PADDR_W       = 3;
    localparam logic [0:0]  REG_RADIX_IDX = 1'b0;

    // Digits and characters
    localparam int          DIGIT_W    = 4;
    localparam int          CHAR_W     = 7;
    localparam logic [6:0]  CHAR_ZERO  = 7'h30;   // '0'
    localparam logic [6:0]  CHAR_A     = 7'h41;   // 'A'
    localparam logic [3:0]  DIGIT_TEN  = 4'd10;

    // Quotient bits produced per cycle by the division step
    localparam int CHUNK_BITS = 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_back_state;

    // Out-of-range register values saturate to the nearest legal radix
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    // 0..9 -> '0'..'9', 10..15 -> 'A'..'F'
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d < DIGIT_TEN) begin
            res = CHAR_ZERO + CHAR_W'(d);
        end else begin
            res = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end
        return res;
    endfunction

    // Restoring long division over one chunk of dividend bits, MSB first.
    // Returns {quotient bits, new remainder}. Remainder stays below radix.
    function automatic logic [CHUNK_BITS+DIGIT_W-1:0] div_chunk(
        input logic [DIGIT_W-1:0]    rem_in,
        input logic [CHUNK_BITS-1:0] bits,
        input logic [RADIX_W-1:0]    radix
    );
        logic [DIGIT_W:0]      t;
        logic [DIGIT_W-1:0]    rem;
        logic [CHUNK_BITS-1:0] q;
        rem = rem_in;
        q   = '0;
        for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
            t = {rem, bits[i]};
            if (t >= radix) begin
                t    = t - radix;
                q[i] = 1'b1;
            end
            rem = t[DIGIT_W-1:0];
        end
        return {q, rem};
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ira_ram.sv
// ----------------------------------------------------------------------------
// ira_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 31
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/ira_queue.sv
// ----------------------------------------------------------------------------
// ira_queue: two-entry request queue between front and back end
// Lets the front accept a request while the back end is still converting.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_queue #(
    parameter int WIDTH = 36
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_cnt,    n_cnt;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// File: hw/rtl/ira_front.sv
// ----------------------------------------------------------------------------
// ira_front: request intake and radix register
// Holds the radix register, takes input requests and tags them with the
// saturated radix before they enter the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_front #(
    parameter int VALUE_WIDTH = ira_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    // configuration port
    input  wire logic                                      psel,
    input  wire logic                                      penable,
    input  wire logic                                      pwrite,
    input  wire logic [ira_pkg::PADDR_W-1:0]               paddr,
    input  wire logic [ira_pkg::APB_DATA_W-1:0]            pwdata,
    output logic      [ira_pkg::APB_DATA_W-1:0]            prdata,
    output logic                                           pready,
    // input requests
    input  wire logic                                      i_valid,
    output logic                                           o_stall,
    input  wire logic [VALUE_WIDTH-1:0]                    i_value,
    // queue side
    input  wire logic                                      i_full,
    output logic                                           o_push,
    output logic      [VALUE_WIDTH+ira_pkg::RADIX_W-1:0]   o_push_data
);

    import ira_pkg::*;

    logic [RADIX_W-1:0] r_radix, n_radix;
    logic               reg_hit;

    // Register decode: word index sits above the byte offset
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_RADIX_IDX);

    always_comb begin
        n_radix = r_radix;
        if (psel && penable && pwrite && reg_hit) begin
            n_radix = pwdata[RADIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else begin
            r_radix <= n_radix;
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_hit ? APB_DATA_W'(r_radix) : '0;

    // Intake: accept whenever the queue has room
    assign o_stall     = i_full;
    assign o_push      = i_valid && !i_full;
    assign o_push_data = {i_value, clamp_radix(r_radix)};

endmodule

`default_nettype wire

// File: hw/rtl/ira_back.sv
// ----------------------------------------------------------------------------
// ira_back: digit generation and character output
// Divides the value by the radix a chunk of bits per cycle, stores each
// remainder as a digit, then plays the digits out most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_back #(
    parameter int VALUE_WIDTH = ira_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    // queue side
    input  wire logic                                     i_job_valid,
    input  wire logic [VALUE_WIDTH+ira_pkg::RADIX_W-1:0]  i_job_data,
    output logic                                          o_job_pop,
    // result channel
    output logic                                          o_valid,
    input  wire logic                                     i_stall,
    output logic      [ira_pkg::CHAR_W-1:0]               o_digit_char,
    output logic                                          o_last_digit
);

    import ira_pkg::*;

    localparam int NCH  = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PADW = NCH * CHUNK_BITS;
    localparam int AW   = $clog2(VALUE_WIDTH);
    localparam int CW   = $clog2(VALUE_WIDTH + 1);
    localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam logic [CHW-1:0] LAST_CHUNK = CHW'(NCH - 1);

    t_back_state          r_state,     n_state;
    logic [PADW-1:0]      r_work,      n_work;
    logic [DIGIT_W-1:0]   r_rem,       n_rem;
    logic [CHW-1:0]       r_chunk,     n_chunk;
    logic [RADIX_W-1:0]   r_radix,     n_radix;
    logic [CW-1:0]        r_count,     n_count;
    logic [CW-1:0]        r_left,      n_left;
    logic                 r_rd_pend,   n_rd_pend;
    logic                 r_rd_last,   n_rd_last;
    logic                 r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]    r_out_char,  n_out_char;
    logic                 r_out_last,  n_out_last;

    logic [CHUNK_BITS+DIGIT_W-1:0] step;
    logic [PADW+CHUNK_BITS-1:0]    shifted;
    logic [CW-1:0]                 left_m1;
    logic                          out_take;
    logic                          ram_we;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [DIGIT_W-1:0]            ram_rdata;

    // Division step over the top chunk of the working register
    assign step    = div_chunk(r_rem, r_work[PADW-1 -: CHUNK_BITS], r_radix);
    assign shifted = {r_work, step[CHUNK_BITS+DIGIT_W-1:DIGIT_W]};
    assign left_m1 = r_left - 1'b1;
    assign out_take = r_out_valid && !i_stall;

    // Digit store
    ira_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_WIDTH)
    ) u_digit_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (step[DIGIT_W-1:0]),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer: next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_work      = r_work;
        n_rem       = r_rem;
        n_chunk     = r_chunk;
        n_radix     = r_radix;
        n_count     = r_count;
        n_left      = r_left;
        n_rd_pend   = 1'b0;
        n_rd_last   = r_rd_last;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_job_pop   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = left_m1[AW-1:0];

        // output register: drain, then refill from a pending read
        if (out_take) begin
            n_out_valid = 1'b0;
        end
        if (r_rd_pend) begin
            n_out_valid = 1'b1;
            n_out_char  = digit_to_ascii(ram_rdata);
            n_out_last  = r_rd_last;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_work    = PADW'(i_job_data[VALUE_WIDTH+RADIX_W-1:RADIX_W]);
                    n_radix   = i_job_data[RADIX_W-1:0];
                    n_rem     = '0;
                    n_chunk   = '0;
                    n_count   = '0;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                n_work = shifted[PADW-1:0];
                if (r_chunk == LAST_CHUNK) begin
                    // one digit finished: store remainder, restart on quotient
                    ram_we  = 1'b1;
                    n_rem   = '0;
                    n_chunk = '0;
                    n_count = r_count + 1'b1;
                    if (shifted[PADW-1:0] == '0) begin
                        n_left  = r_count + 1'b1;
                        n_state = S_EMIT;
                    end
                end else begin
                    n_rem   = step[DIGIT_W-1:0];
                    n_chunk = r_chunk + 1'b1;
                end
            end
            S_EMIT: begin
                if ((r_left != '0) && !r_rd_pend && (!r_out_valid || out_take)) begin
                    ram_re    = 1'b1;
                    n_left    = left_m1;
                    n_rd_pend = 1'b1;
                    n_rd_last = (left_m1 == '0);
                end else if ((r_left == '0) && !r_rd_pend) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_chunk     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_chunk     <= n_chunk;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_work     <= n_work;
        r_rem      <= n_rem;
        r_radix    <= n_radix;
        r_rd_last  <= n_rd_last;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last_digit = r_out_last;

endmodule

`default_nettype wire

// File: hw/rtl/integer_to_radix_ascii.sv
// ----------------------------------------------------------------------------
// integer_to_radix_ascii: integer to ASCII digit string, radix 2 to 16
// A request carries an unsigned value; the block answers with its digits in
// the configured radix as ASCII characters, most significant first, the last
// one flagged by o_last_digit. Zero gives the single character '0'.
//
// Channels: input request i_valid/o_stall/i_value, output o_valid/i_stall
// with o_digit_char and o_last_digit; a transfer happens when valid is high
// and stall is low. The radix register sits at byte address 0 of the APB
// port (reset value 10; values below 2 act as 2, above 16 as 16). Write it
// only while the block is idle.
// Each digit runs the shared divide step over every 8-bit chunk of the value,
// 8 quotient bits a cycle, and each character is read back through the digit
// RAM's registered read port, with one read outstanding at a time.
// A two-entry queue lets new requests be taken while a value is converted.
// Reset empties the queue and the output register. A stalled receiver holds
// the current character; conversion pauses at the next character fetch.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_ascii #(
    parameter int VALUE_WIDTH = ira_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ira_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [ira_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [ira_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    // input requests
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [VALUE_WIDTH-1:0]          i_value,
    // output characters
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic      [ira_pkg::CHAR_W-1:0]      o_digit_char,
    output logic                                 o_last_digit
);

    import ira_pkg::*;

    localparam int JOB_W = VALUE_WIDTH + RADIX_W;

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    logic [JOB_W-1:0] q_in_data;
    logic [JOB_W-1:0] q_out_data;

    // Intake and radix register
    ira_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_push_data (q_in_data)
    );

    // Request queue
    ira_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out_data)
    );

    // Conversion and output
    ira_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .i_job_data   (q_out_data),
        .o_job_pop    (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    // Queue is never written when full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("request queue overflow");

    // Back end only pops a request that exists
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("request queue underflow");

    // Every character shown is a legal digit
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_digit_char >= CHAR_ZERO && o_digit_char <= 7'h39) ||
                     (o_digit_char >= CHAR_A && o_digit_char <= 7'h46)))
        else $error("illegal digit character");

endmodule

`default_nettype wire

// File: tb/integer_to_radix_ascii_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_tb: self-checking bench for the radix string converter
// Requests of random and corner values are sent in several radix settings and
// idle/stall mixes. Each character is checked against a local digit predictor.
// ----------------------------------------------------------------------------

module integer_to_radix_ascii_tb;

    import ira_pkg::*;

    localparam int VW = DEF_VALUE_WIDTH;
    localparam logic [PADDR_W-1:0] RADIX_ADDR = PADDR_W'(4 * REG_RADIX_IDX);

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_exp;

    // DUT signals
    logic                   i_clk;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   i_valid;
    logic                   o_stall;
    logic [VW-1:0]          i_value;
    logic                   o_valid;
    logic                   i_stall;
    logic [CHAR_W-1:0]      o_digit_char;
    logic                   o_last_digit;

    // Bench state
    logic [VW-1:0]  value_queue[$];     // requests not yet presented
    t_char_exp      char_queue[$];      // characters still owed by the block
    logic [4:0]     cfg_radix;          // shadow of the radix register
    logic           feed_en;
    logic           in_fire;            // request taken at the last rising edge
    int             send_idle_pct;
    int             recv_stall_pct;
    int             err_cnt;

    integer_to_radix_ascii u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Expand one value into its characters, most significant first
    function automatic void push_digit_string(input logic [VW-1:0] v);
        logic [4:0]         base;
        logic [VW-1:0]      quot;
        logic [DIGIT_W-1:0] digits[VW+1];
        int                 n;
        t_char_exp          e;
        base = cfg_radix;
        if (base < RADIX_MIN) begin
            base = RADIX_MIN;
        end else if (base > RADIX_MAX) begin
            base = RADIX_MAX;
        end
        quot = v;
        n    = 0;
        // zero still gives one digit
        do begin
            digits[n] = DIGIT_W'(quot % base);
            quot      = quot / base;
            n++;
        end while (quot != '0);
        for (int k = n - 1; k >= 0; k--) begin
            if (digits[k] < DIGIT_TEN) begin
                e.ch = CHAR_ZERO + CHAR_W'(digits[k]);
            end else begin
                e.ch = CHAR_A + CHAR_W'(digits[k] - DIGIT_TEN);
            end
            e.last = (k == 0);
            char_queue = {char_queue, e};
        end
    endfunction

    // Append one request to the pending list
    function automatic void add_request(input logic [VW-1:0] v);
        value_queue = {value_queue, v};
    endfunction

    // Request driver: changes on the falling edge
    always @(negedge i_clk) begin
        logic          nxt_valid;
        logic [VW-1:0] nxt_value;
        nxt_valid = i_valid;
        nxt_value = i_value;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!i_valid || in_fire) begin
            nxt_valid = 1'b0;
            if (feed_en && value_queue.size() > 0 &&
                $urandom_range(99, 0) >= send_idle_pct) begin
                nxt_valid = 1'b1;
                nxt_value = value_queue.pop_front();
            end
        end
        i_valid <= nxt_valid;
        i_value <= nxt_value;
        i_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    // Monitor: predict on accepted requests, check accepted characters
    always @(posedge i_clk) begin
        t_char_exp e;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                push_digit_string(i_value);
            end
            if (o_valid && !i_stall) begin
                if (char_queue.size() == 0) begin
                    $display("%0t: unexpected character: expected none actual %h last %b",
                             $time, o_digit_char, o_last_digit);
                    err_cnt++;
                end else begin
                    e = char_queue.pop_front();
                    if (o_digit_char !== e.ch) begin
                        $display("%0t: digit_char mismatch: expected %h actual %h",
                                 $time, e.ch, o_digit_char);
                        err_cnt++;
                    end
                    if (o_last_digit !== e.last) begin
                        $display("%0t: last_digit mismatch: expected %b actual %b",
                                 $time, e.last, o_last_digit);
                        err_cnt++;
                    end
                end
            end
        end
    end

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SEND: begin
                send_idle_pct  = 72;
                recv_stall_pct = 0;
            end
            IDLE_RECV: begin
                send_idle_pct  = 0;
                recv_stall_pct = 72;
            end
            default: begin
                send_idle_pct  = 25;
                recv_stall_pct = 25;
            end
        endcase
    endtask

    // Register write: setup cycle, then access until pready
    task automatic write_radix(input logic [4:0] r);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= RADIX_ADDR;
        pwdata  <= APB_DATA_W'(r);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cfg_radix = r;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold here until every request is taken and every character is back;
    // checked just after the falling edge, once the driver has settled
    task automatic wait_idle();
        @(negedge i_clk);
        #1;
        while (value_queue.size() > 0 || i_valid || char_queue.size() > 0) begin
            @(negedge i_clk);
            #1;
        end
        repeat (8) @(negedge i_clk);
    endtask

    // Random bit lengths plus zero and all-ones, so that every digit count shows up
    function automatic logic [VW-1:0] rand_value();
        int            w;
        logic [VW-1:0] v;
        w = $urandom_range(VW, 1);
        v = VW'($urandom);
        if ($urandom_range(19, 0) == 0) begin
            v = '1;
        end else if ($urandom_range(19, 0) == 0) begin
            v = '0;
        end else if (w < VW) begin
            v = v & ((VW'(1) << w) - VW'(1));
        end
        return v;
    endfunction

    initial begin
        t_idle_mode mode;
        logic [4:0] r;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_valid        = 1'b0;
        i_value        = '0;
        i_stall        = 1'b0;
        i_rst_n        = 1'b0;
        feed_en        = 1'b0;
        cfg_radix      = RADIX_RESET;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        err_cnt        = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        feed_en = 1'b1;

        // Directed: reset radix, zero, one, extremes
        add_request('0);
        add_request(VW'(1));
        add_request(VW'(9));
        add_request(VW'(10));
        add_request('1);
        add_request(VW'(1234567890));
        wait_idle();

        // Radix below two saturates to binary
        write_radix(5'd0);
        add_request('0);
        add_request('1);
        add_request(VW'(32'h5555_5555));
        wait_idle();
        write_radix(5'd1);
        add_request(VW'(32'h2AAA_AAAA));
        wait_idle();

        // Radix above sixteen saturates to hex
        write_radix(5'd31);
        add_request(VW'(15));
        add_request(VW'(255));
        add_request(VW'(32'h7EDC_BA98));
        wait_idle();
        write_radix(5'd17);
        add_request(VW'(32'h0123_4567));
        wait_idle();
        write_radix(RADIX_MAX);
        add_request('1);
        add_request('0);
        add_request(VW'(32'h4000_0000));
        wait_idle();
        write_radix(RADIX_MIN);
        add_request(VW'(32'h4000_0000));
        add_request(VW'(1));
        wait_idle();

        // Random phases across radix settings and idle mixes
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0:       r = RADIX_MIN;
                1:       r = RADIX_MAX;
                2:       r = 5'd3;
                3:       r = 5'd31;
                default: r = 5'($urandom_range(31, 0));
            endcase
            write_radix(r);
            mode = t_idle_mode'(ph % 4);
            set_idle(mode);
            for (int i = 0; i < 13; i++) begin
                add_request(rand_value());
            end
            wait_idle();
        end

        set_idle(IDLE_NONE);
        repeat (200) @(negedge i_clk);
        if (char_queue.size() != 0) begin
            $display("%0t: %0d characters never arrived", $time, char_queue.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
